### rtl/c80alu_pkg.sv
`timescale 1ns / 1ps

package c80alu_pkg;

  typedef enum logic [4:0] {
    FN_ADD  = 5'd0,
    FN_ADC  = 5'd1,
    FN_SUB  = 5'd2,
    FN_SBB  = 5'd3,
    FN_AND  = 5'd4,
    FN_XOR  = 5'd5,
    FN_OR   = 5'd6,
    FN_CMP  = 5'd7,
    FN_INR  = 5'd8,
    FN_DCR  = 5'd9,
    FN_RLC  = 5'd10,
    FN_RRC  = 5'd11,
    FN_RAL  = 5'd12,
    FN_RAR  = 5'd13,
    FN_DAA  = 5'd14,
    FN_CMA  = 5'd15,
    FN_STC  = 5'd16,
    FN_CMC  = 5'd17,
    FN_DAD  = 5'd18,
    FN_LOAD = 5'd19
  } alu_func_t;

  typedef struct packed {
    logic s;
    logic z;
    logic ac;
    logic p;
    logic cy;
  } alu_flags_t;

  localparam logic [3:0] DAA_LO_LIMIT = 4'd9;
  localparam logic [3:0] DAA_HI_LIMIT = 4'd9;
  localparam logic [7:0] DAA_LO_ADJ   = 8'h06;
  localparam logic [7:0] DAA_HI_ADJ   = 8'h60;

  // even parity: 1 when the count of ones is even
  function automatic logic even_par(input logic [7:0] v);
    return ~^v;
  endfunction

endpackage

### rtl/cpu8080_alu_flags_top.sv
`timescale 1ns / 1ps

// 8080-style ALU holding the accumulator and the five condition flags.
// Input channel: in_valid/in_stall with in_func, in_operand, in_write_acc,
// in_hl_value and in_pair_value; a beat is taken when in_valid is high and
// in_stall is low. Result channel: out_valid/out_stall with the new byte,
// the 16-bit dad sum and the five flags; a beat leaves when out_valid is
// high and out_stall is low.
// Path from input beat to result beat: input register, then the operation
// logic into the result register, which also updates the accumulator and
// flags. Throughput: one beat per cycle while out_stall is low, set by the
// single pass through the adder and flag logic from the input register.
// A stalled result holds in the result register while the input register
// still takes one more beat; in_stall rises only when both are full and
// the receiver stalls.
// Reset clears the accumulator, all flags and both valid bits; no beat is
// in flight afterwards.
module cpu8080_alu_flags_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_func,
  input  logic [7:0]  in_operand,
  input  logic        in_write_acc,
  input  logic [15:0] in_hl_value,
  input  logic [15:0] in_pair_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_result,
  output logic [15:0] out_wide_result,
  output logic        out_sign_flag,
  output logic        out_zero_flag,
  output logic        out_aux_carry_flag,
  output logic        out_parity_flag,
  output logic        out_carry_flag
);
  import c80alu_pkg::*;

  logic        s1_vld_r, s1_vld_nxt;
  logic [4:0]  s1_func_r;
  logic [7:0]  s1_op_r;
  logic        s1_wr_r;
  logic [15:0] s1_hl_r;
  logic [15:0] s1_pair_r;

  logic        out_vld_r;
  logic [7:0]  out_byte_r, byte_nxt;
  logic [15:0] out_wide_r, wide_nxt;

  logic [7:0]  acc_r, acc_nxt;
  alu_flags_t  flg_r, flg_nxt;

  logic        adv;
  logic        in_take;
  logic        fire;

  logic        sub_op;
  logic [7:0]  add_b;
  logic        add_cin;
  logic [8:0]  sum9;
  logic [4:0]  lo5;
  logic [7:0]  incdec;
  logic [16:0] sum17;
  logic [7:0]  daa1;
  logic [8:0]  daa2;
  logic        daa_lo;
  logic        daa_hi;

  assign adv      = ~out_vld_r | ~out_stall;
  assign in_stall = s1_vld_r & ~adv;
  assign in_take  = in_valid & ~in_stall;
  assign fire     = s1_vld_r & adv;

  assign s1_vld_nxt = in_take | (s1_vld_r & ~adv);

  // shared 8-bit adder for add, adc, sub, sbb and cmp
  always_comb begin
    sub_op  = 1'b0;
    add_cin = 1'b0;
    case (s1_func_r)
      FN_ADC: add_cin = flg_r.cy;
      FN_SUB, FN_CMP: begin
        sub_op  = 1'b1;
        add_cin = 1'b1;
      end
      FN_SBB: begin
        sub_op  = 1'b1;
        add_cin = ~flg_r.cy;
      end
      default: begin
        sub_op  = 1'b0;
        add_cin = 1'b0;
      end
    endcase
  end

  assign add_b  = sub_op ? ~s1_op_r : s1_op_r;
  assign sum9   = {1'b0, acc_r} + {1'b0, add_b} + {8'd0, add_cin};
  assign lo5    = {1'b0, acc_r[3:0]} + {1'b0, add_b[3:0]} + {4'd0, add_cin};
  assign incdec = (s1_func_r == FN_INR) ? s1_op_r + 8'd1 : s1_op_r + 8'hFF;
  assign sum17  = {1'b0, s1_hl_r} + {1'b0, s1_pair_r};

  assign daa_lo = (acc_r[3:0] > DAA_LO_LIMIT) | flg_r.ac;
  assign daa1   = daa_lo ? acc_r + DAA_LO_ADJ : acc_r;
  assign daa_hi = (daa1[7:4] > DAA_HI_LIMIT) | flg_r.cy;
  assign daa2   = daa_hi ? {1'b0, daa1} + {1'b0, DAA_HI_ADJ} : {1'b0, daa1};

  always_comb begin
    acc_nxt  = acc_r;
    flg_nxt  = flg_r;
    wide_nxt = '0;
    byte_nxt = acc_r;
    case (s1_func_r)
      FN_ADD, FN_ADC, FN_SUB, FN_SBB, FN_CMP: begin
        if (s1_func_r != FN_CMP) begin
          acc_nxt = sum9[7:0];
        end
        flg_nxt.ac = lo5[4];
        flg_nxt.cy = sub_op ? ~sum9[8] : sum9[8];
        flg_nxt.s  = sum9[7];
        flg_nxt.z  = (sum9[7:0] == 8'd0);
        flg_nxt.p  = even_par(sum9[7:0]);
      end
      FN_AND, FN_XOR, FN_OR: begin
        if (s1_func_r == FN_AND) begin
          acc_nxt = acc_r & s1_op_r;
        end else if (s1_func_r == FN_XOR) begin
          acc_nxt = acc_r ^ s1_op_r;
          flg_nxt.ac = 1'b0;
        end else begin
          acc_nxt = acc_r | s1_op_r;
          flg_nxt.ac = 1'b0;
        end
        flg_nxt.cy = 1'b0;
        flg_nxt.s  = acc_nxt[7];
        flg_nxt.z  = (acc_nxt == 8'd0);
        flg_nxt.p  = even_par(acc_nxt);
      end
      FN_INR, FN_DCR: begin
        flg_nxt.ac = (s1_func_r == FN_INR) ? (s1_op_r[3:0] == 4'hF)
                                           : (s1_op_r[3:0] != 4'h0);
        flg_nxt.s  = incdec[7];
        flg_nxt.z  = (incdec == 8'd0);
        flg_nxt.p  = even_par(incdec);
        if (s1_wr_r) begin
          acc_nxt = incdec;
        end
      end
      FN_RLC: begin
        flg_nxt.cy = acc_r[7];
        acc_nxt    = {acc_r[6:0], acc_r[7]};
      end
      FN_RRC: begin
        flg_nxt.cy = acc_r[0];
        acc_nxt    = {acc_r[0], acc_r[7:1]};
      end
      FN_RAL: begin
        flg_nxt.cy = acc_r[7];
        acc_nxt    = {acc_r[6:0], flg_r.cy};
      end
      FN_RAR: begin
        flg_nxt.cy = acc_r[0];
        acc_nxt    = {flg_r.cy, acc_r[7:1]};
      end
      FN_DAA: begin
        flg_nxt.ac = daa_lo & ({1'b0, acc_r[3:0]} + 5'd6 > 5'd15);
        // carry only ever set here, never cleared
        if (daa2[8]) begin
          flg_nxt.cy = 1'b1;
        end
        acc_nxt   = daa2[7:0];
        flg_nxt.s = daa2[7];
        flg_nxt.z = (daa2[7:0] == 8'd0);
        flg_nxt.p = even_par(daa2[7:0]);
      end
      FN_CMA:  acc_nxt = ~acc_r;
      FN_STC:  flg_nxt.cy = 1'b1;
      FN_CMC:  flg_nxt.cy = ~flg_r.cy;
      FN_DAD: begin
        flg_nxt.cy = sum17[16];
        wide_nxt   = sum17[15:0];
      end
      FN_LOAD: acc_nxt = s1_op_r;
      default: acc_nxt = acc_r;
    endcase
    byte_nxt = (s1_func_r == FN_INR || s1_func_r == FN_DCR) ? incdec : acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      acc_r     <= '0;
      flg_r     <= '0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
      if (fire) begin
        acc_r <= acc_nxt;
        flg_r <= flg_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_op_r   <= in_operand;
      s1_wr_r   <= in_write_acc;
      s1_hl_r   <= in_hl_value;
      s1_pair_r <= in_pair_value;
    end
    if (fire) begin
      out_byte_r <= byte_nxt;
      out_wide_r <= wide_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_byte_result    = out_byte_r;
  assign out_wide_result    = out_wide_r;
  assign out_sign_flag      = flg_r.s;
  assign out_zero_flag      = flg_r.z;
  assign out_aux_carry_flag = flg_r.ac;
  assign out_parity_flag    = flg_r.p;
  assign out_carry_flag     = flg_r.cy;

  // result byte mirrors the accumulator except for inr and dcr
  a_byte_is_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_func_r != FN_INR && s1_func_r != FN_DCR) |=> (out_byte_r == acc_r))
    else $error("result byte differs from accumulator");

  // a held input beat is never dropped while the result side is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !adv) |=> s1_vld_r)
    else $error("input register lost a beat under stall");

  // dad sum appears only for a dad beat
  a_wide_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && s1_func_r != FN_DAD) |=> (out_wide_r == 16'd0))
    else $error("wide result set by a non-dad beat");

endmodule
